@@ rtl/wsfu_pkg.sv @@
// ----------------------------------------------------------------------------
// WebSocket frame unmasker package
// Shared status codes and the result record passed from parser to output.
// ----------------------------------------------------------------------------
package wsfu_pkg;

    // Status reported with the last byte of a buffer.
    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_SHORT = 3'd1,
        ST_TYPE  = 3'd2,
        ST_LONG  = 3'd3,
        ST_TRUNC = 3'd4
    } status_t;

    // One result record, as produced by the parser for an accepted byte.
    typedef struct packed {
        logic        status_valid;
        logic        byte_valid;
        logic [15:0] frame_length;
        status_t     frame_status;
        logic [7:0]  payload_byte;
    } result_t;

endpackage

@@ rtl/wsfu_parser.sv @@
// ----------------------------------------------------------------------------
// WebSocket frame parser
// Per-byte header parse, key capture and payload unmasking in one step.
// ----------------------------------------------------------------------------
module wsfu_parser
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        byte_value,
    input  logic              last_in_buffer,
    output logic              res_valid,
    output wsfu_pkg::result_t res
);

    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_SECOND  = 3'd1,
        PH_LEN_HI  = 3'd2,
        PH_LEN_LO  = 3'd3,
        PH_KEY     = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_DONE    = 3'd6
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] remaining_reg, remaining_next;
    logic [15:0] declared_reg, declared_next;
    logic        mask_present_reg, mask_present_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  key_idx_reg, key_idx_next;
    wsfu_pkg::status_t err_reg, err_next;

    always_comb
    begin
        logic [15:0] len_val;
        logic [7:0]  key_byte;
        logic        use_mask;
        logic        len_ready;
        wsfu_pkg::status_t st;
        logic [15:0] st_len;

        phase_next        = phase_reg;
        remaining_next    = remaining_reg;
        declared_next     = declared_reg;
        mask_present_next = mask_present_reg;
        key_next          = key_reg;
        key_idx_next      = key_idx_reg;
        err_next          = err_reg;
        len_val           = 16'd0;
        use_mask          = 1'b0;
        len_ready         = 1'b0;
        res               = '0;
        res.frame_status  = wsfu_pkg::ST_OK;

        unique case (key_idx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase

        unique case (phase_reg)
            PH_FIRST:
            begin
                declared_next     = 16'd0;
                key_next          = 32'd0;
                mask_present_next = 1'b0;
                key_idx_next      = 2'd0;
                remaining_next    = 16'd0;
                err_next = (!byte_value[7] || byte_value[3:0] != 4'h1) ?
                           wsfu_pkg::ST_TYPE : wsfu_pkg::ST_OK;
                phase_next = PH_SECOND;
            end
            PH_SECOND:
            begin
                if (err_reg != wsfu_pkg::ST_OK)
                begin
                    phase_next = PH_DONE;
                end
                else
                begin
                    mask_present_next = byte_value[7];
                    priority if (byte_value[6:0] == 7'd127)
                    begin
                        err_next   = wsfu_pkg::ST_LONG;
                        phase_next = PH_DONE;
                    end
                    else if (byte_value[6:0] == 7'd126)
                    begin
                        phase_next = PH_LEN_HI;
                    end
                    else
                    begin
                        len_val       = {9'd0, byte_value[6:0]};
                        declared_next = len_val;
                        use_mask      = byte_value[7];
                        len_ready     = 1'b1;
                    end
                end
            end
            PH_LEN_HI:
            begin
                // The high length byte is parked in the remaining counter.
                remaining_next = {byte_value, 8'h00};
                phase_next     = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                len_val       = {remaining_reg[15:8], byte_value};
                declared_next = len_val;
                use_mask      = mask_present_reg;
                len_ready     = 1'b1;
            end
            PH_KEY:
            begin
                key_next     = {key_reg[23:0], byte_value};
                key_idx_next = key_idx_reg + 2'd1;
                if (key_idx_next == 2'd0)
                begin
                    remaining_next = declared_reg;
                    phase_next = (declared_reg != 16'd0) ? PH_PAYLOAD : PH_DONE;
                end
            end
            PH_PAYLOAD:
            begin
                res.payload_byte = byte_value ^ key_byte;
                res.byte_valid   = 1'b1;
                key_idx_next     = key_idx_reg + 2'd1;
                remaining_next   = remaining_reg - 16'd1;
                if (remaining_next == 16'd0)
                begin
                    phase_next = PH_DONE;
                end
            end
            default:
            begin
                // Done, and the unused phase code: bytes are dropped.
            end
        endcase

        // Length is complete: either collect the key or start the payload.
        if (len_ready)
        begin
            key_idx_next = 2'd0;
            if (use_mask)
            begin
                phase_next = PH_KEY;
            end
            else
            begin
                remaining_next = len_val;
                phase_next = (len_val != 16'd0) ? PH_PAYLOAD : PH_DONE;
            end
        end

        st     = wsfu_pkg::ST_OK;
        st_len = 16'd0;
        priority if (phase_next == PH_SECOND)
        begin
            st = wsfu_pkg::ST_SHORT;
        end
        else if (err_next != wsfu_pkg::ST_OK)
        begin
            st = err_next;
        end
        else if (phase_next == PH_LEN_HI || phase_next == PH_LEN_LO)
        begin
            st = wsfu_pkg::ST_TRUNC;
        end
        else if (phase_next == PH_KEY ||
                 (phase_next == PH_PAYLOAD && remaining_next != 16'd0))
        begin
            st     = wsfu_pkg::ST_TRUNC;
            st_len = declared_next;
        end
        else
        begin
            st_len = declared_next;
        end

        if (last_in_buffer)
        begin
            res.status_valid  = 1'b1;
            res.frame_status  = st;
            res.frame_length  = st_len;
            // The next buffer starts from a clean parser.
            phase_next        = PH_FIRST;
            remaining_next    = 16'd0;
            declared_next     = 16'd0;
            mask_present_next = 1'b0;
            key_next          = 32'd0;
            key_idx_next      = 2'd0;
            err_next          = wsfu_pkg::ST_OK;
        end

        res_valid = res.byte_valid || res.status_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_FIRST;
            remaining_reg    <= 16'd0;
            declared_reg     <= 16'd0;
            mask_present_reg <= 1'b0;
            key_reg          <= 32'd0;
            key_idx_reg      <= 2'd0;
            err_reg          <= wsfu_pkg::ST_OK;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            remaining_reg    <= remaining_next;
            declared_reg     <= declared_next;
            mask_present_reg <= mask_present_next;
            key_reg          <= key_next;
            key_idx_reg      <= key_idx_next;
            err_reg          <= err_next;
        end
    end

`ifndef ASSERT_OFF
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_in_buffer |=> phase_reg == PH_FIRST && err_reg == wsfu_pkg::ST_OK)
        else $error("parser not cleared after last byte of buffer");

    a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> remaining_reg != 16'd0)
        else $error("payload phase with no bytes remaining");

    a_key_needs_mask: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_KEY |-> mask_present_reg)
        else $error("key phase entered without mask bit");
`endif

endmodule

@@ rtl/wsfu_out_buf.sv @@
// ----------------------------------------------------------------------------
// WebSocket frame unmasker output buffer
// Output register with one skid entry so input is taken while output stalls.
// ----------------------------------------------------------------------------
module wsfu_out_buf
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  wsfu_pkg::result_t push_data,
    output logic              can_push,
    output logic              out_valid,
    input  logic              out_ready,
    output wsfu_pkg::result_t out_data
);

    logic              out_valid_reg;
    wsfu_pkg::result_t out_data_reg;
    logic              skid_valid_reg;
    wsfu_pkg::result_t skid_data_reg;
    logic              out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign can_push  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && out_ready |=> !skid_valid_reg && out_valid_reg)
        else $error("skid entry not moved to output register");
`endif

endmodule

@@ rtl/websocket_frame_unmasker_core.sv @@
// The per-byte parse step sits between the parser state registers and the
// output register; a result goes to the skid entry behind it while m_axis
// stalls. Throughput: one byte per cycle while the skid entry is free.
// Reset (rst_n low, asynchronous) returns the parser to the first header
// byte and empties the output register and skid entry.
// ----------------------------------------------------------------------------
// WebSocket frame unmasker core
// Parses one WebSocket frame header per received buffer, unmasks the payload
// and reports the frame length and a status on the buffer's last byte.
// ----------------------------------------------------------------------------
module websocket_frame_unmasker_core
(
    input  logic        clk,
    input  logic        rst_n,

    // Input stream: one raw buffer byte per request.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
    input  logic        s_axis_tlast,   // last_in_buffer

    // Output stream: one request per payload byte or per buffer end.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] payload_byte, [10:8] frame_status,
                                        // [26:11] frame_length, [31:27] zero
    output logic        m_axis_tuser,   // byte_valid
    output logic        m_axis_tlast    // status_valid
);

    logic              accept;
    logic              res_valid;
    wsfu_pkg::result_t res;
    logic              can_push;
    wsfu_pkg::result_t out_res;

    // The input is taken whenever the skid entry is free, so a waiting
    // result in the output register does not hold up the next byte.
    assign s_axis_tready = can_push;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // The parser advances its state on every accepted byte and offers a
    // result only for payload bytes and for the buffer's last byte.
    wsfu_parser u_parser
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .byte_value     (s_axis_tdata),
        .last_in_buffer (s_axis_tlast),
        .res_valid      (res_valid),
        .res            (res)
    );

    wsfu_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && res_valid),
        .push_data (res),
        .can_push  (can_push),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_res)
    );

    // Pack the result record onto the output stream.
    assign m_axis_tdata = {5'd0, out_res.frame_length, out_res.frame_status,
                           out_res.payload_byte};
    assign m_axis_tuser = out_res.byte_valid;
    assign m_axis_tlast = out_res.status_valid;

endmodule

@@ tb/sv/unmask_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame unmasker result checker
// Watches both streams of the core. It runs its own model of the frame parser
// on every accepted request, queues the results the core owes and compares
// them in order with what the core delivers.
// ----------------------------------------------------------------------------
module unmask_result_checker
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
    input  logic        s_axis_tlast,   // last_in_buffer

    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // [7:0] payload_byte, [10:8] frame_status,
                                        // [26:11] frame_length, [31:27] zero
    input  logic        m_axis_tuser,   // byte_valid
    input  logic        m_axis_tlast,   // status_valid

    output int          fail_count,
    output int          pending
);

    // Where the parser stands within the current buffer; code 7 is unused.
    typedef enum logic [2:0] {
        HDR_FIRST  = 3'd0,
        HDR_SECOND = 3'd1,
        EXT_HIGH   = 3'd2,
        EXT_LOW    = 3'd3,
        KEY_BYTES  = 3'd4,
        PAYLOAD    = 3'd5,
        DONE       = 3'd6
    } parse_phase_t;

    parse_phase_t      phase;
    logic [15:0]       left_bytes;
    logic [15:0]       frame_len;
    logic              masked;
    logic [31:0]       key_word;
    logic [1:0]        key_idx;
    wsfu_pkg::status_t err_code;

    wsfu_pkg::result_t unmasked_out_q[$];
    int                fail_total = 0;

    assign fail_count = fail_total;

    function automatic void clear_parser();
        phase      = HDR_FIRST;
        left_bytes = 16'd0;
        frame_len  = 16'd0;
        masked     = 1'b0;
        key_word   = 32'd0;
        key_idx    = 2'd0;
        err_code   = wsfu_pkg::ST_OK;
    endfunction

    // The length is complete: a masked frame reads its key next.
    function automatic void length_known();
        if (masked) begin
            phase   = KEY_BYTES;
            key_idx = 2'd0;
        end
        else begin
            left_bytes = frame_len;
            key_idx    = 2'd0;
            phase      = (frame_len != 16'd0) ? PAYLOAD : DONE;
        end
    endfunction

    // Advances the parser by one buffer byte and forms the result it causes.
    function automatic void parse_frame_byte(input logic [7:0] b, input logic last,
                                             output logic emits,
                                             output wsfu_pkg::result_t res);
        logic [7:0] key_b;
        res = '0;
        case (phase)
            HDR_FIRST:
            begin
                frame_len  = 16'd0;
                key_word   = 32'd0;
                masked     = 1'b0;
                key_idx    = 2'd0;
                left_bytes = 16'd0;
                err_code   = (!b[7] || b[3:0] != 4'h1) ? wsfu_pkg::ST_TYPE
                                                       : wsfu_pkg::ST_OK;
                phase      = HDR_SECOND;
            end
            HDR_SECOND:
            begin
                if (err_code != wsfu_pkg::ST_OK)
                begin
                    phase = DONE;
                end
                else
                begin
                    masked = b[7];
                    if (b[6:0] == 7'd127)
                    begin
                        err_code = wsfu_pkg::ST_LONG;
                        phase    = DONE;
                    end
                    else if (b[6:0] == 7'd126)
                    begin
                        phase = EXT_HIGH;
                    end
                    else
                    begin
                        frame_len = {9'd0, b[6:0]};
                        length_known();
                    end
                end
            end
            EXT_HIGH:
            begin
                // The high byte waits in the down counter until the low byte comes.
                left_bytes = {b, 8'h00};
                phase      = EXT_LOW;
            end
            EXT_LOW:
            begin
                frame_len = {left_bytes[15:8], b};
                length_known();
            end
            KEY_BYTES:
            begin
                key_word = {key_word[23:0], b};
                key_idx  = key_idx + 2'd1;
                if (key_idx == 2'd0)
                begin
                    left_bytes = frame_len;
                    phase      = (frame_len != 16'd0) ? PAYLOAD : DONE;
                end
            end
            PAYLOAD:
            begin
                key_b            = key_word[8 * (3 - key_idx) +: 8];
                res.payload_byte = b ^ key_b;
                res.byte_valid   = 1'b1;
                key_idx          = key_idx + 2'd1;
                left_bytes       = left_bytes - 16'd1;
                if (left_bytes == 16'd0)
                    phase = DONE;
            end
            default:
            begin
            end
        endcase

        emits = res.byte_valid || last;
        if (last)
        begin
            res.status_valid = 1'b1;
            if (phase == HDR_SECOND)
                res.frame_status = wsfu_pkg::ST_SHORT;
            else if (err_code != wsfu_pkg::ST_OK)
                res.frame_status = err_code;
            else if (phase == EXT_HIGH || phase == EXT_LOW)
                res.frame_status = wsfu_pkg::ST_TRUNC;
            else
            begin
                res.frame_length = frame_len;
                if (phase == KEY_BYTES || (phase == PAYLOAD && left_bytes != 16'd0))
                    res.frame_status = wsfu_pkg::ST_TRUNC;
                else
                    res.frame_status = wsfu_pkg::ST_OK;
            end
            clear_parser();
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        wsfu_pkg::result_t want;
        wsfu_pkg::result_t got;
        logic              emits;
        if (!rst_n)
        begin
            clear_parser();
            unmasked_out_q = {};
            pending <= 0;
        end
        else
        begin
            // Input first, so that even a result with no register stage finds its entry.
            if (s_axis_tvalid && s_axis_tready)
            begin
                parse_frame_byte(s_axis_tdata, s_axis_tlast, emits, want);
                if (emits)
                    unmasked_out_q.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.payload_byte = m_axis_tdata[7:0];
                got.frame_status = wsfu_pkg::status_t'(m_axis_tdata[10:8]);
                got.frame_length = m_axis_tdata[26:11];
                got.byte_valid   = m_axis_tuser;
                got.status_valid = m_axis_tlast;
                if (unmasked_out_q.size() == 0)
                begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("%0t: unexpected result: byte %02h bv %0b sv %0b st %0d len %0d",
                                 $time, got.payload_byte, got.byte_valid, got.status_valid,
                                 got.frame_status, got.frame_length);
                end
                else
                begin
                    want = unmasked_out_q.pop_front();
                    if (got !== want || m_axis_tdata[31:27] !== 5'd0)
                    begin
                        fail_total++;
                        if (fail_total <= 10)
                            $display({"%0t: mismatch: expected byte %02h bv %0b sv %0b st %0d ",
                                      "len %0d, got byte %02h bv %0b sv %0b st %0d len %0d ",
                                      "pad %02h"},
                                     $time, want.payload_byte, want.byte_valid,
                                     want.status_valid, want.frame_status, want.frame_length,
                                     got.payload_byte, got.byte_valid, got.status_valid,
                                     got.frame_status, got.frame_length, m_axis_tdata[31:27]);
                    end
                end
            end
            pending <= unmasked_out_q.size();
        end
    end

endmodule

@@ tb/sv/websocket_frame_unmasker_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame unmasker core test
// Feeds the core with buffers of directed and random frames, with random gaps
// on the input and random stalls on the output, and reports the verdict from
// the result checker that runs beside it.
// ----------------------------------------------------------------------------
module websocket_frame_unmasker_core_test;

    // Generous bound: every byte waiting out the longest sender gap and the
    // longest receiver stall still ends far below it.
    localparam int CYCLE_LIMIT = 400000;

    // Roughly how many meaningful buffer bytes the random part sends.
    localparam int RANDOM_BYTES = 1350;

    logic        clk;
    logic        rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] byte_value
    logic        s_axis_tlast = 1'b0;    // last_in_buffer

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;           // [7:0] payload_byte, [10:8] frame_status,
                                         // [26:11] frame_length, [31:27] zero
    logic        m_axis_tuser;           // byte_valid
    logic        m_axis_tlast;           // status_valid

    int          fail_count;
    int          pending;

    // When calm is set, neither side idles, so full-rate stretches occur.
    logic        calm = 1'b0;

    // The buffer being assembled, and how many meaningful bytes have gone out.
    logic [7:0]  frame_q[$];
    int          counted = 0;
    int          cycle_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    websocket_frame_unmasker_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    unmask_result_checker result_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // A hung handshake or a result that never comes ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Offers one byte after a random gap and returns at the edge that takes it.
    // The valid is only lowered when a gap follows, so back-to-back requests
    // never see a low and a high assigned in the same time step.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 12);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // Sends the assembled buffer, marking its final byte.
    task automatic send_buffer(input int useful);
        for (int i = 0; i < frame_q.size(); i++)
            send_byte(frame_q[i], i == frame_q.size() - 1);
        counted += useful;
    endtask

    // Assembles one frame: header, optional 16-bit length, optional key,
    // payload bytes and trailing bytes that the parser has to ignore.
    task automatic build_frame(input logic [7:0] first, input logic masked,
                               input logic [15:0] len, input logic ext,
                               input int body, input int extra);
        frame_q = {};
        frame_q.push_back(first);
        if (ext)
        begin
            frame_q.push_back({masked, 7'd126});
            frame_q.push_back(len[15:8]);
            frame_q.push_back(len[7:0]);
        end
        else
        begin
            frame_q.push_back({masked, len[6:0]});
        end
        if (masked)
            repeat (4) frame_q.push_back(8'($urandom_range(0, 255)));
        repeat (body + extra) frame_q.push_back(8'($urandom_range(0, 255)));
    endtask

    // Holds the sender off until the core has delivered every owed result.
    // The valid is lowered before the wait begins.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Receiver: a fresh stall is drawn for every result it takes.
    initial
    begin : sink
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 12);
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    initial
    begin : stimulus
        int          pick;
        int          whole;
        int          cut;
        int          extra;
        logic        masked;
        logic        ext;
        logic [15:0] len;
        logic [7:0]  first;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A lone final text header is still too short.
        frame_q = {8'h81};
        send_buffer(1);
        // A lone byte that is no text header reports too short as well.
        frame_q = {8'h00};
        send_buffer(1);
        // Binary frame: wrong type, no payload.
        frame_q = {8'h82, 8'h05};
        send_buffer(2);
        // Masked length code 127 is rejected as too long.
        frame_q = {8'h81, 8'hFF};
        send_buffer(2);
        // Zero length, no key: a complete empty frame.
        frame_q = {8'h81, 8'h00};
        send_buffer(2);
        // Masked two-byte payload followed by a byte past the payload.
        build_frame(8'h81, 1'b1, 16'd2, 1'b0, 2, 1);
        send_buffer(9);
        // Extended length cut after its high byte.
        frame_q = {8'h81, 8'h7E, 8'hFF};
        send_buffer(3);
        // Largest extended length, masked, buffer ends inside the key.
        build_frame(8'h81, 1'b1, 16'hFFFF, 1'b1, 0, 0);
        while (frame_q.size() > 6)
            void'(frame_q.pop_back());
        send_buffer(6);

        drain();

        // Random part: mostly well-formed frames with random content, some
        // cut short, some with length code 127, and some plain noise.
        while (counted < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 15) == 0)
                calm <= !calm;
            if ($urandom_range(0, 40) == 0)
                drain();
            pick   = $urandom_range(0, 99);
            first  = ($urandom_range(0, 3) == 0) ? {1'b1, 3'($urandom_range(0, 7)), 4'h1}
                                                 : 8'h81;
            masked = 1'($urandom_range(0, 1));
            if (pick < 80)
            begin
                ext = ($urandom_range(0, 4) == 0);
                if (ext && pick >= 65)
                    len = 16'($urandom_range(0, 65535));
                else if (ext)
                    len = 16'($urandom_range(0, 300));
                else if ($urandom_range(0, 9) == 0)
                    len = 16'($urandom_range(26, 125));
                else
                    len = 16'($urandom_range(0, 25));
                extra = (pick < 65 && $urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
                // Broken frames never carry more than a short piece of payload.
                build_frame(first, masked, len, ext,
                            (pick >= 65 && len > 16'd60) ? 60 : int'(len), extra);
                whole = frame_q.size() - extra;
                if (pick >= 65)
                begin
                    cut = $urandom_range(1, whole);
                    while (frame_q.size() > cut)
                        void'(frame_q.pop_back());
                    whole = cut;
                end
                send_buffer(whole);
            end
            else if (pick < 88)
            begin
                frame_q = {first, {masked, 7'h7F}};
                repeat ($urandom_range(0, 3)) frame_q.push_back(8'($urandom_range(0, 255)));
                send_buffer(2);
            end
            else
            begin
                frame_q = {};
                repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom_range(0, 255)));
                send_buffer((frame_q.size() < 2) ? frame_q.size() : 2);
            end
        end

        // Wait for every owed result, then keep watching for strays before the verdict.
        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
